FILE: src/serial_line_editor_core_defines.svh
// ---------------------------------------------------------------------------
// Serial line editor assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SERIAL_LINE_EDITOR_CORE_DEFINES_SVH
`define SERIAL_LINE_EDITOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sle_pkg.sv
// ---------------------------------------------------------------------------
// Serial line editor package
// Constants, result word type and byte classification shared by the editor.
// ---------------------------------------------------------------------------
package sle_pkg;

  localparam int unsigned LINE_DEPTH = 64;
  localparam int unsigned ADDR_W     = $clog2(LINE_DEPTH);
  localparam int unsigned CAP_W      = 7;
  localparam int unsigned CAP_EXT_W  = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd238;
  localparam logic [7:0] LEAD1_LO = 8'h81;
  localparam logic [7:0] LEAD1_HI = 8'h9f;
  localparam logic [7:0] LEAD2_LO = 8'he0;
  localparam logic [7:0] LEAD2_HI = 8'hee;

  localparam logic [2:0] NRES_ONE    = 3'd1;
  localparam logic [2:0] NRES_ERASE1 = 3'd3;
  localparam logic [2:0] NRES_ERASE2 = 3'd6;

  typedef struct packed {
    logic              echo_valid;
    logic [7:0]        echo_byte;
    logic              store_valid;
    logic [ADDR_W-1:0] store_index;
    logic [7:0]        store_byte;
    logic              line_done;
    logic              aborted;
    logic [ADDR_W-1:0] line_length;
  } sle_res_t;

  function automatic logic is_lead(input logic [7:0] c);
    return ((c >= LEAD1_LO) && (c <= LEAD1_HI)) || ((c >= LEAD2_LO) && (c <= LEAD2_HI));
  endfunction

endpackage

FILE: src/sle_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module sle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/serial_line_editor_core.sv
// ---------------------------------------------------------------------------
// Serial line editor core
// Edits a console input line held in a RAM and emits echo and store words.
// ---------------------------------------------------------------------------
// Each received byte passes a decode stage, which reads the line RAM as the
// byte is accepted, at the entry two places below the write index (for the
// double-byte check of backspace), and then a result register that delivers
// one word per cycle while out_ready is high. A byte yields one result word,
// or three or six words for a backspace on a non-empty line, so the block
// takes one byte per cycle while bytes yield single words and out_ready is
// high; else a new byte waits in the decode stage until the last word is taken.
module serial_line_editor_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_echo_valid,
  output logic [7:0]                 out_echo_byte,
  output logic                       out_store_valid,
  output logic [sle_pkg::ADDR_W-1:0] out_store_index,
  output logic [7:0]                 out_store_byte,
  output logic                       out_line_done,
  output logic                       out_aborted,
  output logic [sle_pkg::ADDR_W-1:0] out_line_length,
  output logic                       out_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sle_pkg::CAP_W-1:0]  cfg_line_capacity
);

  logic [sle_pkg::CAP_W-1:0]     cap_r;
  logic [sle_pkg::ADDR_W-1:0]    wi_r, wi_nxt, wi_c;
  logic                          trail_r, trail_nxt, trail_c;
  logic                          skip_r, skip_nxt, skip_c;
  logic                          x_valid_r, x_valid_nxt;
  logic [7:0]                    x_byte_r;
  logic                          job_valid_r, job_valid_nxt;
  sle_pkg::sle_res_t             job_r, res_c;
  logic                          erase_r, erase_c;
  logic [2:0]                    step_r, nres_r, nres_c;
  logic                          we_c;
  logic [sle_pkg::ADDR_W-1:0]    waddr_c;
  logic [7:0]                    wdata_c;
  logic [7:0]                    rdata;
  logic [sle_pkg::ADDR_W-1:0]    raddr;
  logic [sle_pkg::CAP_EXT_W-1:0] cap_ext, cap_eff, i_ext;
  logic                          pair_fit, print_fit;
  logic                          x_adv, in_acc, out_acc, last_c, job_free;

  assign cfg_ready = 1'b1;

  assign cap_ext   = sle_pkg::CAP_EXT_W'(cap_r);
  assign cap_eff   = (cap_ext > sle_pkg::CAP_EXT_W'(sle_pkg::LINE_DEPTH)) ?
                     sle_pkg::CAP_EXT_W'(sle_pkg::LINE_DEPTH) : cap_ext;
  assign i_ext     = sle_pkg::CAP_EXT_W'(wi_r);
  assign pair_fit  = (i_ext + sle_pkg::CAP_EXT_W'(3)) <= cap_eff;
  assign print_fit = (i_ext + sle_pkg::CAP_EXT_W'(1)) < cap_eff;

  always_comb begin
    res_c             = '0;
    res_c.line_length = wi_r;
    wi_c              = wi_r;
    trail_c           = trail_r;
    skip_c            = skip_r;
    erase_c           = 1'b0;
    nres_c            = sle_pkg::NRES_ONE;
    we_c              = 1'b0;
    waddr_c           = wi_r;
    wdata_c           = x_byte_r;
    if (trail_r) begin
      trail_c           = 1'b0;
      we_c              = 1'b1;
      wi_c              = wi_r + 1'b1;
      res_c.echo_valid  = 1'b1;
      res_c.echo_byte   = x_byte_r;
      res_c.store_valid = 1'b1;
      res_c.store_index = wi_r;
      res_c.store_byte  = x_byte_r;
      res_c.line_length = wi_r + 1'b1;
    end else if (skip_r) begin
      skip_c = 1'b0;
    end else if (x_byte_r == sle_pkg::CH_ESC) begin
      we_c              = 1'b1;
      waddr_c           = '0;
      wdata_c           = sle_pkg::CH_NUL;
      wi_c              = '0;
      res_c.store_valid = 1'b1;
      res_c.aborted     = 1'b1;
      res_c.line_length = '0;
    end else if (x_byte_r == sle_pkg::CH_CR) begin
      we_c              = 1'b1;
      wdata_c           = sle_pkg::CH_NUL;
      wi_c              = '0;
      res_c.echo_valid  = 1'b1;
      res_c.echo_byte   = sle_pkg::CH_CR;
      res_c.store_valid = 1'b1;
      res_c.store_index = wi_r;
      res_c.line_done   = 1'b1;
    end else if (x_byte_r == sle_pkg::CH_BS) begin
      if (wi_r != '0) begin
        erase_c           = 1'b1;
        res_c.echo_valid  = 1'b1;
        res_c.echo_byte   = sle_pkg::CH_BS;
        res_c.line_length = wi_r - 1'b1;
        if ((wi_r > sle_pkg::ADDR_W'(1)) && sle_pkg::is_lead(rdata)) begin
          wi_c   = wi_r - sle_pkg::ADDR_W'(2);
          nres_c = sle_pkg::NRES_ERASE2;
        end else begin
          wi_c   = wi_r - 1'b1;
          nres_c = sle_pkg::NRES_ERASE1;
        end
      end
    end else if (sle_pkg::is_lead(x_byte_r)) begin
      if (pair_fit) begin
        we_c              = 1'b1;
        wi_c              = wi_r + 1'b1;
        trail_c           = 1'b1;
        res_c.echo_valid  = 1'b1;
        res_c.echo_byte   = x_byte_r;
        res_c.store_valid = 1'b1;
        res_c.store_index = wi_r;
        res_c.store_byte  = x_byte_r;
        res_c.line_length = wi_r + 1'b1;
      end else begin
        skip_c = 1'b1;
      end
    end else if (x_byte_r == sle_pkg::CH_NUL) begin
      skip_c = 1'b1;
    end else if ((x_byte_r >= sle_pkg::PRINT_LO) && (x_byte_r <= sle_pkg::PRINT_HI) &&
                 print_fit) begin
      we_c              = 1'b1;
      wi_c              = wi_r + 1'b1;
      res_c.echo_valid  = 1'b1;
      res_c.echo_byte   = x_byte_r;
      res_c.store_valid = 1'b1;
      res_c.store_index = wi_r;
      res_c.store_byte  = x_byte_r;
      res_c.line_length = wi_r + 1'b1;
    end
  end

  assign last_c   = !erase_r || (step_r == (nres_r - 3'd1));
  assign out_acc  = out_valid && out_ready;
  assign job_free = !job_valid_r || (out_acc && last_c);
  assign x_adv    = x_valid_r && job_free;
  assign in_ready = !x_valid_r || x_adv;
  assign in_acc   = in_valid && in_ready;

  assign wi_nxt        = x_adv ? wi_c : wi_r;
  assign trail_nxt     = x_adv ? trail_c : trail_r;
  assign skip_nxt      = x_adv ? skip_c : skip_r;
  assign x_valid_nxt   = in_acc || (x_valid_r && !x_adv);
  assign job_valid_nxt = x_adv || (job_valid_r && !(out_acc && last_c));
  assign raddr         = wi_nxt - sle_pkg::ADDR_W'(2);

  sle_ram #(
    .WIDTH (8),
    .DEPTH (sle_pkg::LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (x_adv && we_c),
    .waddr (waddr_c),
    .wdata (wdata_c),
    .re    (in_acc),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= sle_pkg::CAP_RESET;
      wi_r        <= '0;
      trail_r     <= 1'b0;
      skip_r      <= 1'b0;
      x_valid_r   <= 1'b0;
      job_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_line_capacity;
      end
      wi_r        <= wi_nxt;
      trail_r     <= trail_nxt;
      skip_r      <= skip_nxt;
      x_valid_r   <= x_valid_nxt;
      job_valid_r <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_byte_r <= in_rx_byte;
    end
    if (x_adv) begin
      job_r   <= res_c;
      erase_r <= erase_c;
      nres_r  <= nres_c;
      step_r  <= '0;
    end else if (out_acc) begin
      step_r <= step_r + 3'd1;
    end
  end

  assign out_valid       = job_valid_r;
  assign out_echo_valid  = job_r.echo_valid;
  assign out_echo_byte   = (erase_r && ((step_r == 3'd1) || (step_r == 3'd4))) ?
                           sle_pkg::CH_SP : job_r.echo_byte;
  assign out_store_valid = job_r.store_valid;
  assign out_store_index = job_r.store_index;
  assign out_store_byte  = job_r.store_byte;
  assign out_line_done   = job_r.line_done;
  assign out_aborted     = job_r.aborted;
  assign out_line_length = (erase_r && (step_r >= 3'd3)) ?
                           (job_r.line_length - 1'b1) : job_r.line_length;
  assign out_last        = last_c;

`include "serial_line_editor_core_defines.svh"

  `SLE_ASSERT_SAME(a_trail_skip_excl, trail_r, !skip_r, "Trail and skip flags both set.")
  `SLE_ASSERT_SAME(a_step_range, job_valid_r && erase_r, step_r < nres_r, "Erase step overrun.")
  `SLE_ASSERT_NEXT(a_burst_cont, out_valid && out_ready && !out_last, out_valid, "Burst cut short.")

endmodule
